FILE: rtl/luds_pkg.sv
// luds_pkg: shared word types, a saturation helper and a magnitude helper for the LU solve unit.
// No dependencies.
`timescale 1ns / 1ps

package luds_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] dword_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  function automatic word_t sat32(input dword_t v);
    word_t r;
    if (v > dword_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < dword_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input word_t v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

FILE: rtl/lu_decompose_and_solve_unit.sv
// lu_decompose_and_solve_unit: LU factoring with scaled partial pivoting and solve.
// Depends on luds_pkg, luds_mul, luds_div.
//
// Usage: stream N*N matrix elements (in_kind 0, row-major, Q16.16) over the
// valid/ready input. After the last one the unit factors the matrix in place and
// transfers one result holding the saturated determinant and the singular status.
// Then stream N right-hand-side elements (in_kind 1); the unit runs forward and
// back substitution and transfers N solution elements, the last one flagged.
// More right-hand sides may follow and reuse the factors. N comes from cfg_wdata.
// Loading takes one element per cycle. Factoring runs on one shared multiplier,
// one shared divider and one factor memory with a read and a write port, and
// performs N*(N-1)/2 divides to eliminate the rows below each pivot.
// in_ready is low while factoring or substituting. A waiting result sits in the
// output register; the unit keeps taking input and stalls only when a new
// result finds that register still full. Reset clears control state and sets
// N to 4; factor data is undefined until loaded.
`timescale 1ns / 1ps

module lu_decompose_and_solve_unit #(
  parameter int MAX_ORDER = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_solution,
  output logic [31:0] out_determinant,
  output logic        out_status,
  output logic        out_last_item
);

  localparam int IW    = $clog2(MAX_ORDER);
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int LW    = 2 * CW;
  localparam int AW    = 2 * IW;
  localparam int MEM_D = 1 << AW;
  localparam luds_pkg::word_t ONE_Q = luds_pkg::word_t'(64'sd1 <<< FRAC_BITS);

  localparam logic [5:0] S_IDLE = 6'd0,  S_SC_RD = 6'd1,  S_SC_AC = 6'd2,
                         S_PV_INIT = 6'd3, S_PV_RD = 6'd4, S_PV_M1 = 6'd5,
                         S_PV_M2 = 6'd6, S_PV_M3 = 6'd7,  S_PV_M4 = 6'd8,
                         S_SW_CHK = 6'd9, S_SW_RA = 6'd10, S_SW_RB = 6'd11,
                         S_SW_W1 = 6'd12, S_SW_W2 = 6'd13, S_PK_RD = 6'd14,
                         S_PK_CK = 6'd15, S_EL_RD = 6'd16, S_EL_DV = 6'd17,
                         S_EL_WR = 6'd18, S_UP_RB = 6'd19, S_UP_RA = 6'd20,
                         S_UP_WR = 6'd21, S_EL_NX = 6'd22, S_K_NEXT = 6'd23,
                         S_DT_RD = 6'd24, S_DT_M = 6'd25, S_DT_AC = 6'd26,
                         S_DT_OUT = 6'd27, S_FW_INIT = 6'd28, S_FW_RD = 6'd29,
                         S_FW_M = 6'd30, S_FW_AC = 6'd31, S_FW_ST = 6'd32,
                         S_BK_INIT = 6'd33, S_BK_PC = 6'd34, S_BK_RD = 6'd35,
                         S_BK_M = 6'd36, S_BK_AC = 6'd37, S_BK_DV = 6'd38,
                         S_BK_WR = 6'd39, S_SO_OUT = 6'd40, S_MW1 = 6'd41,
                         S_MW2 = 6'd42, S_DW = 6'd43;

  function automatic logic [AW-1:0] addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {r[IW-1:0], c[IW-1:0]};
  endfunction

  // control state
  logic [5:0]    state_r, state_nxt, ret_r, ret_nxt;
  logic [4:0]    order_r;
  logic          rhs_r, rhs_nxt, sing_r, sing_nxt, par_r, par_nxt;
  logic [LW-1:0] lc_r, lc_nxt;
  logic          ov_r, ov_nxt;

  // datapath state
  logic [CW-1:0]    row_r, row_nxt, col_r, col_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, imax_r, imax_nxt;
  logic [31:0]      big_r, big_nxt, bm_r, bm_nxt, bs_r, bs_nxt, m_r, m_nxt, s_r, s_nxt;
  logic signed [65:0] p1_r, p1_nxt;
  luds_pkg::word_t  f_r, f_nxt, pv_r, pv_nxt, tmp_r, tmp_nxt, a_r, a_nxt, det_r, det_nxt;
  luds_pkg::dword_t acc_r, acc_nxt;
  logic signed [32:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [31:0]      scale_r [MAX_ORDER];
  logic [31:0]      scale_nxt [MAX_ORDER];
  logic [IW-1:0]    piv_r [MAX_ORDER];
  logic [IW-1:0]    piv_nxt [MAX_ORDER];
  luds_pkg::word_t  wv_r [MAX_ORDER];
  luds_pkg::word_t  wv_nxt [MAX_ORDER];
  luds_pkg::word_t  sol_r, sol_nxt, dout_r, dout_nxt;
  logic             st_r, st_nxt, last_r, last_nxt;

  // factor memory
  logic [31:0]   mem [MEM_D];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  // shared units
  logic signed [65:0] prod;
  luds_pkg::dword_t   qrnd;
  logic               div_start, div_done;
  luds_pkg::word_t    div_num, div_den, div_q;

  logic [CW-1:0] n;
  logic [LW-1:0] nn, elc;
  logic [CW-1:0] erow, ecol;
  logic          slot_free;
  logic [31:0]   mg, bn;
  logic [IW-1:0] ipx;

  luds_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .a(ma_r), .b(mb_r), .prod(prod), .qrnd(qrnd)
  );

  luds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    if (order_r == 5'd0) begin
      n = CW'(1);
    end else if (int'(order_r) > MAX_ORDER) begin
      n = CW'(MAX_ORDER);
    end else begin
      n = CW'(order_r);
    end
    nn = LW'(n) * LW'(n);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;   rhs_nxt = rhs_r;  sing_nxt = sing_r;
    par_nxt   = par_r;    lc_nxt  = lc_r;    row_nxt = row_r;  col_nxt  = col_r;
    i_nxt     = i_r;      j_nxt   = j_r;     k_nxt   = k_r;    imax_nxt = imax_r;
    big_nxt   = big_r;    bm_nxt  = bm_r;    bs_nxt  = bs_r;   m_nxt    = m_r;
    s_nxt     = s_r;      p1_nxt  = p1_r;    f_nxt   = f_r;    pv_nxt   = pv_r;
    tmp_nxt   = tmp_r;    a_nxt   = a_r;     det_nxt = det_r;  acc_nxt  = acc_r;
    ma_nxt    = ma_r;     mb_nxt  = mb_r;    sol_nxt = sol_r;  dout_nxt = dout_r;
    st_nxt    = st_r;     last_nxt = last_r;
    scale_nxt = scale_r;  piv_nxt = piv_r;   wv_nxt  = wv_r;
    ov_nxt    = ov_r && !out_ready;
    mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  mem_ra = '0;
    div_start = 1'b0;  div_num = '0;  div_den = '0;
    elc  = rhs_r ? '0 : lc_r;
    erow = rhs_r ? '0 : row_r;
    ecol = rhs_r ? '0 : col_r;
    mg   = luds_pkg::mag32(rdata);
    bn   = (mg > big_r) ? mg : big_r;
    ipx  = (CW'(piv_r[i_r[IW-1:0]]) >= n) ? i_r[IW-1:0] : piv_r[i_r[IW-1:0]];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_kind) begin
            rhs_nxt = 1'b0;
            if (elc < nn) begin
              mem_we = 1'b1;
              mem_wa = addr(erow, ecol);
              mem_wd = in_value;
            end
            if (elc + LW'(1) >= nn) begin
              lc_nxt = '0;  row_nxt = '0;  col_nxt = '0;
              i_nxt = '0;   j_nxt = '0;    big_nxt = '0;
              sing_nxt = 1'b0;  par_nxt = 1'b0;
              state_nxt = S_SC_RD;
            end else begin
              lc_nxt = elc + LW'(1);
              if (ecol + CW'(1) >= n) begin
                col_nxt = '0;
                row_nxt = erow + CW'(1);
              end else begin
                col_nxt = ecol + CW'(1);
                row_nxt = erow;
              end
            end
          end else if (rhs_r) begin
            if (lc_r < LW'(n)) wv_nxt[lc_r[IW-1:0]] = in_value;
            if (lc_r + LW'(1) < LW'(n)) begin
              lc_nxt = lc_r + LW'(1);
            end else begin
              lc_nxt = '0;
              i_nxt = '0;
              state_nxt = S_FW_INIT;
            end
          end
        end
      end
      S_SC_RD: begin
        mem_ra = addr(i_r, j_r);
        state_nxt = S_SC_AC;
      end
      S_SC_AC: begin
        if (j_r + CW'(1) < n) begin
          big_nxt = bn;
          j_nxt = j_r + CW'(1);
          state_nxt = S_SC_RD;
        end else begin
          scale_nxt[i_r[IW-1:0]] = (bn == 32'd0) ? 32'd1 : bn;
          if (bn == 32'd0) sing_nxt = 1'b1;
          big_nxt = '0;
          j_nxt = '0;
          if (i_r + CW'(1) < n) begin
            i_nxt = i_r + CW'(1);
            state_nxt = S_SC_RD;
          end else begin
            k_nxt = '0;
            state_nxt = S_PV_INIT;
          end
        end
      end
      S_PV_INIT: begin
        i_nxt = k_r;  bm_nxt = '0;  bs_nxt = 32'd1;  imax_nxt = k_r;
        state_nxt = S_PV_RD;
      end
      S_PV_RD: begin
        mem_ra = addr(i_r, k_r);
        state_nxt = S_PV_M1;
      end
      S_PV_M1: begin
        m_nxt = mg;
        s_nxt = (scale_r[i_r[IW-1:0]] == 32'd0) ? 32'd1 : scale_r[i_r[IW-1:0]];
        ma_nxt = {1'b0, mg};
        mb_nxt = {1'b0, bs_r};
        state_nxt = S_PV_M2;
      end
      S_PV_M2: begin
        ma_nxt = {1'b0, bm_r};
        mb_nxt = {1'b0, s_r};
        state_nxt = S_PV_M3;
      end
      S_PV_M3: begin
        p1_nxt = prod;
        state_nxt = S_PV_M4;
      end
      S_PV_M4: begin
        if (p1_r > prod) begin
          bm_nxt = m_r;  bs_nxt = s_r;  imax_nxt = i_r;
        end
        if (i_r + CW'(1) < n) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_PV_RD;
        end else begin
          state_nxt = S_SW_CHK;
        end
      end
      S_SW_CHK: begin
        piv_nxt[k_r[IW-1:0]] = imax_r[IW-1:0];
        j_nxt = '0;
        if (imax_r != k_r) begin
          par_nxt = !par_r;
          scale_nxt[imax_r[IW-1:0]] = scale_r[k_r[IW-1:0]];
          state_nxt = S_SW_RA;
        end else begin
          state_nxt = S_PK_RD;
        end
      end
      S_SW_RA: begin
        mem_ra = addr(imax_r, j_r);
        state_nxt = S_SW_RB;
      end
      S_SW_RB: begin
        mem_ra = addr(k_r, j_r);
        tmp_nxt = rdata;
        state_nxt = S_SW_W1;
      end
      S_SW_W1: begin
        mem_we = 1'b1;  mem_wa = addr(imax_r, j_r);  mem_wd = rdata;
        state_nxt = S_SW_W2;
      end
      S_SW_W2: begin
        mem_we = 1'b1;  mem_wa = addr(k_r, j_r);  mem_wd = tmp_r;
        if (j_r + CW'(1) < n) begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_SW_RA;
        end else begin
          state_nxt = S_PK_RD;
        end
      end
      S_PK_RD: begin
        mem_ra = addr(k_r, k_r);
        state_nxt = S_PK_CK;
      end
      S_PK_CK: begin
        pv_nxt = (rdata == 32'd0) ? 32'sd1 : rdata;
        if (rdata == 32'd0) begin
          mem_we = 1'b1;  mem_wa = addr(k_r, k_r);  mem_wd = 32'd1;
        end
        if (k_r + CW'(1) < n) begin
          i_nxt = k_r + CW'(1);
          state_nxt = S_EL_RD;
        end else begin
          state_nxt = S_K_NEXT;
        end
      end
      S_EL_RD: begin
        mem_ra = addr(i_r, k_r);
        state_nxt = S_EL_DV;
      end
      S_EL_DV: begin
        div_start = 1'b1;  div_num = rdata;  div_den = pv_r;
        ret_nxt = S_EL_WR;
        state_nxt = S_DW;
      end
      S_EL_WR: begin
        f_nxt = div_q;
        mem_we = 1'b1;  mem_wa = addr(i_r, k_r);  mem_wd = div_q;
        j_nxt = k_r + CW'(1);
        state_nxt = S_UP_RB;
      end
      S_UP_RB: begin
        mem_ra = addr(k_r, j_r);
        state_nxt = S_UP_RA;
      end
      S_UP_RA: begin
        mem_ra = addr(i_r, j_r);
        ma_nxt = {f_r[31], f_r};
        mb_nxt = {rdata[31], rdata};
        ret_nxt = S_UP_WR;
        state_nxt = S_MW1;
      end
      S_UP_WR: begin
        mem_we = 1'b1;  mem_wa = addr(i_r, j_r);
        mem_wd = luds_pkg::sat32(luds_pkg::dword_t'(a_r) - qrnd);
        if (j_r + CW'(1) < n) begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_UP_RB;
        end else begin
          state_nxt = S_EL_NX;
        end
      end
      S_EL_NX: begin
        if (i_r + CW'(1) < n) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_EL_RD;
        end else begin
          state_nxt = S_K_NEXT;
        end
      end
      S_K_NEXT: begin
        if (k_r + CW'(1) < n) begin
          k_nxt = k_r + CW'(1);
          state_nxt = S_PV_INIT;
        end else begin
          det_nxt = par_r ? -ONE_Q : ONE_Q;
          i_nxt = '0;
          state_nxt = S_DT_RD;
        end
      end
      S_DT_RD: begin
        mem_ra = addr(i_r, i_r);
        state_nxt = S_DT_M;
      end
      S_DT_M: begin
        ma_nxt = {det_r[31], det_r};
        mb_nxt = {rdata[31], rdata};
        ret_nxt = S_DT_AC;
        state_nxt = S_MW1;
      end
      S_DT_AC: begin
        det_nxt = luds_pkg::sat32(qrnd);
        if (i_r + CW'(1) < n) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_DT_RD;
        end else begin
          state_nxt = S_DT_OUT;
        end
      end
      S_DT_OUT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          sol_nxt = '0;  dout_nxt = det_r;  st_nxt = sing_r;  last_nxt = 1'b0;
          rhs_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FW_INIT: begin
        acc_nxt = luds_pkg::dword_t'(wv_r[ipx]);
        wv_nxt[ipx] = wv_r[i_r[IW-1:0]];
        j_nxt = '0;
        state_nxt = (i_r != '0) ? S_FW_RD : S_FW_ST;
      end
      S_FW_RD: begin
        mem_ra = addr(i_r, j_r);
        state_nxt = S_FW_M;
      end
      S_FW_M: begin
        ma_nxt = {rdata[31], rdata};
        mb_nxt = {wv_r[j_r[IW-1:0]][31], wv_r[j_r[IW-1:0]]};
        ret_nxt = S_FW_AC;
        state_nxt = S_MW1;
      end
      S_FW_AC: begin
        acc_nxt = acc_r - qrnd;
        if (j_r + CW'(1) < i_r) begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_FW_RD;
        end else begin
          state_nxt = S_FW_ST;
        end
      end
      S_FW_ST: begin
        wv_nxt[i_r[IW-1:0]] = luds_pkg::sat32(acc_r);
        if (i_r + CW'(1) < n) begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_FW_INIT;
        end else begin
          i_nxt = n - CW'(1);
          state_nxt = S_BK_INIT;
        end
      end
      S_BK_INIT: begin
        acc_nxt = luds_pkg::dword_t'(wv_r[i_r[IW-1:0]]);
        j_nxt = i_r + CW'(1);
        mem_ra = addr(i_r, i_r);
        state_nxt = S_BK_PC;
      end
      S_BK_PC: begin
        pv_nxt = rdata;
        state_nxt = (j_r < n) ? S_BK_RD : S_BK_DV;
      end
      S_BK_RD: begin
        mem_ra = addr(i_r, j_r);
        state_nxt = S_BK_M;
      end
      S_BK_M: begin
        ma_nxt = {rdata[31], rdata};
        mb_nxt = {wv_r[j_r[IW-1:0]][31], wv_r[j_r[IW-1:0]]};
        ret_nxt = S_BK_AC;
        state_nxt = S_MW1;
      end
      S_BK_AC: begin
        acc_nxt = acc_r - qrnd;
        if (j_r + CW'(1) < n) begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_BK_RD;
        end else begin
          state_nxt = S_BK_DV;
        end
      end
      S_BK_DV: begin
        div_start = 1'b1;  div_num = luds_pkg::sat32(acc_r);  div_den = pv_r;
        ret_nxt = S_BK_WR;
        state_nxt = S_DW;
      end
      S_BK_WR: begin
        wv_nxt[i_r[IW-1:0]] = div_q;
        if (i_r != '0) begin
          i_nxt = i_r - CW'(1);
          state_nxt = S_BK_INIT;
        end else begin
          state_nxt = S_SO_OUT;
        end
      end
      S_SO_OUT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          sol_nxt = wv_r[i_r[IW-1:0]];  dout_nxt = '0;  st_nxt = sing_r;
          last_nxt = (i_r + CW'(1) >= n);
          if (i_r + CW'(1) < n) begin
            i_nxt = i_r + CW'(1);
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MW1: begin
        a_nxt = rdata;
        state_nxt = S_MW2;
      end
      S_MW2: begin
        state_nxt = ret_r;
      end
      S_DW: begin
        if (div_done) state_nxt = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      order_r <= 5'd4;
      rhs_r   <= 1'b0;
      sing_r  <= 1'b0;
      par_r   <= 1'b0;
      lc_r    <= '0;
      row_r   <= '0;
      col_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) order_r <= cfg_wdata;
      rhs_r   <= rhs_nxt;
      sing_r  <= sing_nxt;
      par_r   <= par_nxt;
      lc_r    <= lc_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r   <= ret_nxt;   i_r   <= i_nxt;    j_r    <= j_nxt;    k_r    <= k_nxt;
    imax_r  <= imax_nxt;  big_r <= big_nxt;  bm_r   <= bm_nxt;   bs_r   <= bs_nxt;
    m_r     <= m_nxt;     s_r   <= s_nxt;    p1_r   <= p1_nxt;   f_r    <= f_nxt;
    pv_r    <= pv_nxt;    tmp_r <= tmp_nxt;  a_r    <= a_nxt;    det_r  <= det_nxt;
    acc_r   <= acc_nxt;   ma_r  <= ma_nxt;   mb_r   <= mb_nxt;   sol_r  <= sol_nxt;
    dout_r  <= dout_nxt;  st_r  <= st_nxt;   last_r <= last_nxt;
    scale_r <= scale_nxt; piv_r <= piv_nxt;  wv_r   <= wv_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  assign out_valid       = ov_r;
  assign out_solution    = sol_r;
  assign out_determinant = dout_r;
  assign out_status      = st_r;
  assign out_last_item   = last_r;

endmodule

FILE: rtl/luds_mul.sv
// luds_mul: shared two-stage signed multiplier with Q-format rounding.
// Depends on luds_pkg.
`timescale 1ns / 1ps

module luds_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic signed [32:0]  a,
  input  logic signed [32:0]  b,
  output logic signed [65:0]  prod,
  output luds_pkg::dword_t    qrnd
);

  logic signed [65:0] prod_r;
  luds_pkg::dword_t   qrnd_r;
  logic               neg;
  logic [65:0]        mabs;
  logic [63:0]        rnd;
  luds_pkg::dword_t   qv;

  always_comb begin
    neg  = prod_r[65];
    mabs = neg ? (~prod_r + 66'd1) : prod_r;
    rnd  = (mabs[63:0] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    qv   = neg ? -luds_pkg::dword_t'(rnd) : luds_pkg::dword_t'(rnd);
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    qrnd_r <= qv;
  end

  assign prod = prod_r;
  assign qrnd = qrnd_r;

endmodule

FILE: rtl/luds_div.sv
// luds_div: radix-2 restoring divider for rounded Q-format quotients.
// Depends on luds_pkg.
`timescale 1ns / 1ps

module luds_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  luds_pkg::word_t num,
  input  luds_pkg::word_t den,
  output logic            done,
  output luds_pkg::word_t quo
);

  localparam int QW   = 33 + FRAC_BITS;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r, done_r, neg_r;
  logic [CNTW-1:0] cnt_r;
  logic [QW-1:0]   dvd_r;
  logic [31:0]     rem_r, d_r;
  luds_pkg::word_t quo_r;

  logic [31:0]      dm, dd;
  logic [QW-1:0]    dvd0;
  logic [32:0]      rt, rsub;
  logic             ge;
  luds_pkg::dword_t qv, sq;

  always_comb begin
    dm   = luds_pkg::mag32(den);
    dd   = (dm == 32'd0) ? 32'd1 : dm;
    dvd0 = (QW'(luds_pkg::mag32(num)) << FRAC_BITS) + QW'(dd >> 1);
    rt   = {rem_r, dvd_r[QW-1]};
    ge   = rt >= {1'b0, d_r};
    rsub = rt - {1'b0, d_r};
    qv   = luds_pkg::dword_t'({{(64 - QW){1'b0}}, dvd_r});
    sq   = neg_r ? -qv : qv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNTW'(QW);
      dvd_r <= dvd0;
      rem_r <= 32'd0;
      d_r   <= dd;
      neg_r <= num[31] ^ den[31];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= ge ? rsub[31:0] : rt[31:0];
        dvd_r <= {dvd_r[QW-2:0], ge};
        cnt_r <= cnt_r - CNTW'(1);
      end else begin
        quo_r <= luds_pkg::sat32(sq);
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: rtl/luds_chk.sv
// luds_chk: port-level checks for the LU solve unit, bound to the top level.
// Depends on lu_decompose_and_solve_unit.
`timescale 1ns / 1ps

module luds_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_solution,
  input logic [31:0] out_determinant,
  input logic        out_last_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_solution)
      && $stable(out_determinant) && $stable(out_last_item))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_last_det: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_item |-> out_determinant == 32'd0)
    else $error("last solution carries determinant");

  a_det_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_determinant != 32'd0 |-> out_solution == 32'd0 && !out_last_item)
    else $error("determinant result mixed with solution");

endmodule

bind lu_decompose_and_solve_unit luds_chk u_luds_chk (.*);
